// File: src/flv_tag_demultiplexer_top_defines.svh
// ----------------------------------------------------------------------------
// FLV tag demultiplexer: assertion macros
// Shared assertion forms for the demultiplexer modules. Each macro expects
// clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FLV_TAG_DEMULTIPLEXER_TOP_DEFINES_SVH
`define FLV_TAG_DEMULTIPLEXER_TOP_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define FLVD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define FLVD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent holds in the following cycle.
`define FLVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/flvd_pkg.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer package
// Types and constants shared by the parser, the command queue and the
// result sequencer.
// ----------------------------------------------------------------------------
package flvd_pkg;

  localparam int HEADER_BYTES   = 9;
  localparam int ZERO_PAD_BYTES = 4;
  localparam int REPLAY_LEN     = HEADER_BYTES + ZERO_PAD_BYTES;
  localparam int HDR_IW         = $clog2(HEADER_BYTES);
  localparam int REP_IW         = $clog2(REPLAY_LEN);
  localparam int OFFSET_POS     = 5;   // first byte of the big-endian data offset
  localparam int PREV_BYTES     = 4;
  localparam int TAGHDR_BYTES   = 11;
  localparam int FIFO_DEPTH     = 4;

  localparam logic [7:0] TYPE_AUDIO = 8'd8;
  localparam logic [7:0] TYPE_VIDEO = 8'd9;

  localparam logic [1:0] KIND_AUDIO = 2'd0;
  localparam logic [1:0] KIND_VIDEO = 2'd1;
  localparam logic [1:0] KIND_DESC  = 2'd2;

  localparam logic CFG_AUDIO_ENABLE = 1'b0;
  localparam logic CFG_VIDEO_ENABLE = 1'b1;

  typedef logic [HEADER_BYTES-1:0][7:0] hdr_bytes_t;

  // One queue entry: what a single accepted byte asks the back end to emit.
  typedef struct packed {
    logic        replay;
    logic        desc;
    logic        byte_en;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  tag_type;
    logic [23:0] tag_size;
    logic [23:0] time_stamp;
    logic        first_valid;
    logic [7:0]  first_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  tag_type;
    logic [23:0] tag_size;
    logic [23:0] time_stamp;
    logic [3:0]  sound_format;
    logic [1:0]  sound_rate;
    logic        sound_size;
    logic        sound_channels;
    logic [3:0]  frame_kind;
    logic [3:0]  codec_id;
  } out_item_t;

endpackage

// File: src/flvd_front.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer: parser front end
// Walks the file header, the skip region and the tag loop one byte a beat
// and turns every byte into at most one command for the result sequencer.
// ----------------------------------------------------------------------------
`include "flv_tag_demultiplexer_top_defines.svh"

module flvd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_wdata,
  input  logic                 byte_accept,
  input  logic [7:0]           file_byte,
  output logic                 cmd_push,
  output flvd_pkg::cmd_t       cmd,
  output flvd_pkg::hdr_bytes_t hdr_bytes
);

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_SKIP    = 5'b00010,
    PH_PREV    = 5'b00100,
    PH_TAGHDR  = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [23:0] size_r, size_nxt;
  logic [23:0] stamp_r, stamp_nxt;
  logic        vbegun_r, vbegun_nxt;
  logic        avideo_r, avideo_nxt;
  logic        aen_r, ven_r;
  logic        hdr_we;
  logic [31:0] cnt_inc;
  logic [31:0] offset;
  logic [7:0]  type_now;
  flvd_pkg::hdr_bytes_t hdr_r;

  assign hdr_bytes = hdr_r;
  assign cmd_push  = byte_accept && (cmd.replay || cmd.desc || cmd.byte_en);
  assign cnt_inc   = cnt_r + 32'd1;
  assign offset    = {hdr_r[flvd_pkg::OFFSET_POS], hdr_r[flvd_pkg::OFFSET_POS+1],
                      hdr_r[flvd_pkg::OFFSET_POS+2], file_byte};
  assign type_now  = (cnt_r == 32'd0) ? file_byte : type_r;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    skip_nxt   = skip_r;
    type_nxt   = type_r;
    size_nxt   = size_r;
    stamp_nxt  = stamp_r;
    vbegun_nxt = vbegun_r;
    avideo_nxt = avideo_r;
    hdr_we     = 1'b0;
    cmd        = '0;
    cmd.data   = file_byte;
    if (byte_accept) begin
      case (phase_r)
        PH_HEADER: begin
          hdr_we  = 1'b1;
          cnt_nxt = cnt_inc;
          if (cnt_inc == 32'(flvd_pkg::HEADER_BYTES)) begin
            skip_nxt = offset;
            if (offset <= 32'(flvd_pkg::HEADER_BYTES)) begin
              phase_nxt = PH_PREV;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= skip_r) begin
            phase_nxt = PH_PREV;
            cnt_nxt   = '0;
          end
        end
        PH_PREV: begin
          cmd.byte_en = avideo_r && ven_r;
          cmd.kind    = flvd_pkg::KIND_VIDEO;
          cnt_nxt     = cnt_inc;
          if (cnt_inc == 32'(flvd_pkg::PREV_BYTES)) begin
            avideo_nxt = 1'b0;
            phase_nxt  = PH_TAGHDR;
            cnt_nxt    = '0;
          end
        end
        PH_TAGHDR: begin
          if (cnt_r == 32'd0) begin
            type_nxt  = file_byte;
            size_nxt  = '0;
            stamp_nxt = '0;
            if (file_byte == flvd_pkg::TYPE_VIDEO && ven_r && !vbegun_r) begin
              cmd.replay = 1'b1;
              vbegun_nxt = 1'b1;
            end
          end else if (cnt_r <= 32'd3) begin
            size_nxt = {size_r[15:0], file_byte};
          end else if (cnt_r <= 32'd6) begin
            stamp_nxt = {stamp_r[15:0], file_byte};
          end
          // The descriptor of a tag with no payload byte to wait for goes out
          // on the last tag header byte.
          if (cnt_r == 32'(flvd_pkg::TAGHDR_BYTES - 1)) begin
            cmd.desc = !(type_r == flvd_pkg::TYPE_AUDIO || type_r == flvd_pkg::TYPE_VIDEO)
                       || (size_r == 24'd0);
          end
          cmd.tag_type   = type_r;
          cmd.tag_size   = size_r;
          cmd.time_stamp = stamp_r;
          cmd.byte_en    = (type_now == flvd_pkg::TYPE_VIDEO) && ven_r;
          cmd.kind       = flvd_pkg::KIND_VIDEO;
          cnt_nxt        = cnt_inc;
          if (cnt_inc == 32'(flvd_pkg::TAGHDR_BYTES)) begin
            cnt_nxt = '0;
            if (size_r == 24'd0) begin
              if (type_r == flvd_pkg::TYPE_VIDEO) begin
                avideo_nxt = 1'b1;
              end
              phase_nxt = PH_PREV;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          cmd.tag_type    = type_r;
          cmd.tag_size    = size_r;
          cmd.time_stamp  = stamp_r;
          cmd.first_valid = 1'b1;
          cmd.first_byte  = file_byte;
          if (type_r == flvd_pkg::TYPE_AUDIO) begin
            cmd.desc    = (cnt_r == 32'd0);
            cmd.byte_en = (cnt_r != 32'd0) && aen_r;
            cmd.kind    = flvd_pkg::KIND_AUDIO;
          end else if (type_r == flvd_pkg::TYPE_VIDEO) begin
            cmd.desc    = (cnt_r == 32'd0);
            cmd.byte_en = ven_r;
            cmd.kind    = flvd_pkg::KIND_VIDEO;
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= {8'd0, size_r}) begin
            if (type_r == flvd_pkg::TYPE_VIDEO) begin
              avideo_nxt = 1'b1;
            end
            phase_nxt = PH_PREV;
            cnt_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      cnt_r    <= '0;
      skip_r   <= '0;
      type_r   <= '0;
      size_r   <= '0;
      stamp_r  <= '0;
      vbegun_r <= 1'b0;
      avideo_r <= 1'b0;
      aen_r    <= 1'b1;
      ven_r    <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      skip_r   <= skip_nxt;
      type_r   <= type_nxt;
      size_r   <= size_nxt;
      stamp_r  <= stamp_nxt;
      vbegun_r <= vbegun_nxt;
      avideo_r <= avideo_nxt;
      if (cfg_we && cfg_index == flvd_pkg::CFG_AUDIO_ENABLE) begin
        aen_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == flvd_pkg::CFG_VIDEO_ENABLE) begin
        ven_r <= cfg_wdata;
      end
    end
  end

  // The header store has no reset; it is written once while the header passes.
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[cnt_r[flvd_pkg::HDR_IW-1:0]] <= file_byte;
    end
  end

  `FLVD_ASSERT_IMPL(a_hdr_cnt, phase_r == PH_HEADER, cnt_r < 32'(flvd_pkg::HEADER_BYTES), "header count overran")
  `FLVD_ASSERT_IMPL(a_prev_cnt, phase_r == PH_PREV, cnt_r < 32'(flvd_pkg::PREV_BYTES), "previous-size count overran")
  `FLVD_ASSERT_IMPL(a_taghdr_cnt, phase_r == PH_TAGHDR, cnt_r < 32'(flvd_pkg::TAGHDR_BYTES), "tag header count overran")
  `FLVD_ASSERT_IMPL(a_replay_once, cmd_push && cmd.replay, !vbegun_r, "header replay issued twice")

endmodule

// File: src/flvd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer: command queue
// A short first-in first-out queue that decouples the parser from the
// result sequencer. The head entry is visible without a read cycle.
// ----------------------------------------------------------------------------
`include "flv_tag_demultiplexer_top_defines.svh"

module flvd_cmd_fifo #(
  parameter int DEPTH = flvd_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  flvd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output flvd_pkg::cmd_t head_cmd,
  output logic           head_valid,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  flvd_pkg::cmd_t       mem_r [DEPTH];
  logic [PW-1:0]        wptr_r, wptr_nxt;
  logic [PW-1:0]        rptr_r, rptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;

  assign head_cmd   = mem_r[rptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == CW'(DEPTH));

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  `FLVD_ASSERT_ALWAYS(a_count_range, count_r <= CW'(DEPTH), "queue count beyond depth")
  `FLVD_ASSERT_IMPL(a_no_overflow, full, !push || pop, "push into a full queue")
  `FLVD_ASSERT_IMPL(a_no_underflow, pop, head_valid, "pop from an empty queue")

endmodule

// File: src/flvd_back.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer: result sequencer
// Expands the head command into its results (header replay, descriptor,
// routed byte) one a cycle into the output register while it is free or taken.
// ----------------------------------------------------------------------------
`include "flv_tag_demultiplexer_top_defines.svh"

module flvd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  flvd_pkg::cmd_t       head_cmd,
  input  logic                 head_valid,
  input  flvd_pkg::hdr_bytes_t hdr_bytes,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output flvd_pkg::out_item_t  out_item
);

  logic [flvd_pkg::REP_IW-1:0] rep_idx_r, rep_idx_nxt;
  logic                        rep_done_r, rep_done_nxt;
  logic                        desc_done_r, desc_done_nxt;
  logic                        out_valid_r, out_valid_nxt;
  flvd_pkg::out_item_t         out_item_r, item;
  logic                        load, last;
  logic                        rep_active, desc_active, rep_end;

  assign out_valid   = out_valid_r;
  assign out_item    = out_item_r;
  assign load        = head_valid && (!out_valid_r || out_ready);
  assign rep_active  = head_cmd.replay && !rep_done_r;
  assign desc_active = head_cmd.desc && !desc_done_r;
  assign rep_end     = (rep_idx_r == flvd_pkg::REP_IW'(flvd_pkg::REPLAY_LEN - 1));
  assign pop         = load && last;

  always_comb begin
    item = '0;
    last = 1'b1;
    if (rep_active) begin
      item.kind = flvd_pkg::KIND_VIDEO;
      // Header bytes first, then the zero previous-tag-size.
      if (rep_idx_r < flvd_pkg::REP_IW'(flvd_pkg::HEADER_BYTES)) begin
        item.out_byte = hdr_bytes[rep_idx_r[flvd_pkg::HDR_IW-1:0]];
      end
      last = rep_end && !head_cmd.desc && !head_cmd.byte_en;
    end else if (desc_active) begin
      item.kind       = flvd_pkg::KIND_DESC;
      item.tag_type   = head_cmd.tag_type;
      item.tag_size   = head_cmd.tag_size;
      item.time_stamp = head_cmd.time_stamp;
      if (head_cmd.first_valid && head_cmd.tag_type == flvd_pkg::TYPE_AUDIO) begin
        item.sound_format   = head_cmd.first_byte[7:4];
        item.sound_rate     = head_cmd.first_byte[3:2];
        item.sound_size     = head_cmd.first_byte[1];
        item.sound_channels = head_cmd.first_byte[0];
      end else if (head_cmd.first_valid && head_cmd.tag_type == flvd_pkg::TYPE_VIDEO) begin
        item.frame_kind = head_cmd.first_byte[7:4];
        item.codec_id   = head_cmd.first_byte[3:0];
      end
      last = !head_cmd.byte_en;
    end else begin
      item.kind     = head_cmd.kind;
      item.out_byte = head_cmd.data;
    end
  end

  always_comb begin
    rep_idx_nxt   = rep_idx_r;
    rep_done_nxt  = rep_done_r;
    desc_done_nxt = desc_done_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      if (rep_active) begin
        rep_idx_nxt = rep_end ? '0 : rep_idx_r + flvd_pkg::REP_IW'(1);
        if (rep_end) begin
          rep_done_nxt = 1'b1;
        end
      end else if (desc_active) begin
        desc_done_nxt = 1'b1;
      end
      if (last) begin
        rep_idx_nxt   = '0;
        rep_done_nxt  = 1'b0;
        desc_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_idx_r   <= '0;
      rep_done_r  <= 1'b0;
      desc_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rep_idx_r   <= rep_idx_nxt;
      rep_done_r  <= rep_done_nxt;
      desc_done_r <= desc_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= item;
    end
  end

  `FLVD_ASSERT_ALWAYS(a_rep_idx, rep_idx_r <= flvd_pkg::REP_IW'(flvd_pkg::REPLAY_LEN - 1), "replay index out of range")
  `FLVD_ASSERT_NEXT(a_load_shows, load, out_valid_r, "loaded result not presented")
  `FLVD_ASSERT_IMPL(a_replay_then_byte, rep_active && rep_end, head_cmd.byte_en, "replay without its type byte")

endmodule

// File: src/flv_tag_demultiplexer_top.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer top level
// Splits an FLV byte stream into audio bytes, video stream bytes and tag
// descriptors.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one file byte per beat (in_valid/in_ready);
// the result channel gives one result per beat (out_valid/out_ready), whose
// out_kind says audio byte, video byte or tag descriptor. The cfg port writes
// the audio or the video enable, chosen by cfg_index; write them only while idle.
// Throughput: one byte accepted per cycle while the command queue has room.
// A byte causes zero, one or two results, except the type byte of the first
// routed video tag, which causes fourteen (header replay, four zero bytes and
// the byte itself); the sequencer emits one result a cycle while out_ready
// allows, so such bursts back-pressure the input through the queue.
// Path: an accepted byte's command is first written into the queue; its first
// result is then loaded from the queue head into the output register.
// Stalls: when out_ready is low the output register holds its result and the
// queue absorbs up to FIFO_DEPTH commands before in_ready drops.
// Reset: synchronous, active low; parsing restarts at the file header and
// both enables return to one. No clearing pass is needed.
// ----------------------------------------------------------------------------
module flv_tag_demultiplexer_top #(
  parameter int FIFO_DEPTH = flvd_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_tag_type,
  output logic [23:0] out_tag_size,
  output logic [23:0] out_time_stamp,
  output logic [3:0]  out_sound_format,
  output logic [1:0]  out_sound_rate,
  output logic        out_sound_size,
  output logic        out_sound_channels,
  output logic [3:0]  out_frame_kind,
  output logic [3:0]  out_codec_id
);

  logic                 byte_accept;
  logic                 cmd_push, cmd_pop, head_valid, fifo_full;
  flvd_pkg::cmd_t       push_cmd, head_cmd;
  flvd_pkg::hdr_bytes_t hdr_bytes;
  flvd_pkg::out_item_t  item;

  assign in_ready    = !fifo_full;
  assign byte_accept = in_valid && in_ready;

  flvd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .byte_accept (byte_accept),
    .file_byte   (in_file_byte),
    .cmd_push    (cmd_push),
    .cmd         (push_cmd),
    .hdr_bytes   (hdr_bytes)
  );

  flvd_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (push_cmd),
    .pop        (cmd_pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .full       (fifo_full)
  );

  flvd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .hdr_bytes  (hdr_bytes),
    .pop        (cmd_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (item)
  );

  assign out_kind           = item.kind;
  assign out_byte           = item.out_byte;
  assign out_tag_type       = item.tag_type;
  assign out_tag_size       = item.tag_size;
  assign out_time_stamp     = item.time_stamp;
  assign out_sound_format   = item.sound_format;
  assign out_sound_rate     = item.sound_rate;
  assign out_sound_size     = item.sound_size;
  assign out_sound_channels = item.sound_channels;
  assign out_frame_kind     = item.frame_kind;
  assign out_codec_id       = item.codec_id;

endmodule

// File: test/tb_flv_tag_demultiplexer_top.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer testbench
// Feeds a single FLV byte stream: a fixed opening (file header and an empty
// video tag that triggers the header replay), then phases of random but
// well-formed tags under different audio and video enable settings. Every
// accepted byte is run through a behavioural parser here, and each result
// beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_flv_tag_demultiplexer_top;

  localparam logic [7:0] TYPE_SCRIPT = 8'd18;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 90;
  localparam int PHASES        = 5;
  localparam int PHASE_BYTES   = 30;

  typedef enum logic [4:0] {
    P_HEADER = 5'b00001,
    P_SKIP   = 5'b00010,
    P_PREV   = 5'b00100,
    P_TAGHDR = 5'b01000,
    P_BODY   = 5'b10000
  } parse_phase_t;
  typedef enum int {FORM_MODEL, FORM_QUIET, FORM_TYPED} row_form_t;

  typedef struct {
    logic [7:0]          value;
    row_form_t           form;
    flvd_pkg::out_item_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_file_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  out_tag_type;
  logic [23:0] out_tag_size;
  logic [23:0] out_time_stamp;
  logic [3:0]  out_sound_format;
  logic [1:0]  out_sound_rate;
  logic        out_sound_size;
  logic        out_sound_channels;
  logic [3:0]  out_frame_kind;
  logic [3:0]  out_codec_id;

  flv_tag_demultiplexer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_file_byte       (in_file_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_byte           (out_byte),
    .out_tag_type       (out_tag_type),
    .out_tag_size       (out_tag_size),
    .out_time_stamp     (out_time_stamp),
    .out_sound_format   (out_sound_format),
    .out_sound_rate     (out_sound_rate),
    .out_sound_size     (out_sound_size),
    .out_sound_channels (out_sound_channels),
    .out_frame_kind     (out_frame_kind),
    .out_codec_id       (out_codec_id)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state mirrored in the testbench.
  parse_phase_t phase = P_HEADER;
  int unsigned  pos = 0;
  logic [7:0]   hdr_copy [flvd_pkg::HEADER_BYTES];
  logic [31:0]  data_offset = '0;
  logic [7:0]   cur_type = '0;
  logic [23:0]  cur_size = '0;
  logic [23:0]  cur_stamp = '0;
  logic         replay_done = 1'b0;
  logic         after_vid = 1'b0;
  logic         audio_on = 1'b1;
  logic         video_on = 1'b1;

  flvd_pkg::out_item_t fresh [$];
  flvd_pkg::out_item_t results_due [$];
  stim_row_t beat_queue [$];
  stim_row_t cur_row;
  stim_row_t intro [24];
  flvd_pkg::out_item_t head;

  int failures = 0;
  int bytes_taken = 0;
  int n_audio = 0;
  int n_video = 0;
  int n_desc = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_wanted = 1'b0;
  int ready_mode = 0;
  int mode_left = 0;
  int tick = 0;

  function automatic flvd_pkg::out_item_t echo(input logic [7:0] b);
    flvd_pkg::out_item_t r;
    r = '0;
    r.kind = flvd_pkg::KIND_VIDEO;
    r.out_byte = b;
    return r;
  endfunction

  task automatic add_byte(input logic [1:0] kind, input logic [7:0] b);
    flvd_pkg::out_item_t r;
    r = '0;
    r.kind = kind;
    r.out_byte = b;
    fresh.push_back(r);
  endtask

  task automatic add_desc(input bit has_first, input logic [7:0] first);
    flvd_pkg::out_item_t r;
    r = '0;
    r.kind = flvd_pkg::KIND_DESC;
    r.tag_type = cur_type;
    r.tag_size = cur_size;
    r.time_stamp = cur_stamp;
    if (has_first && cur_type == flvd_pkg::TYPE_AUDIO) begin
      r.sound_format = first[7:4];
      r.sound_rate = first[3:2];
      r.sound_size = first[1];
      r.sound_channels = first[0];
    end else if (has_first && cur_type == flvd_pkg::TYPE_VIDEO) begin
      r.frame_kind = first[7:4];
      r.codec_id = first[3:0];
    end
    fresh.push_back(r);
  endtask

  // Works out the results that one accepted file byte causes.
  task automatic demux_byte(input logic [7:0] b);
    int i;
    case (phase)
      P_HEADER: begin
        hdr_copy[pos] = b;
        pos++;
        if (pos >= flvd_pkg::HEADER_BYTES) begin
          data_offset = {hdr_copy[flvd_pkg::OFFSET_POS], hdr_copy[flvd_pkg::OFFSET_POS+1],
                         hdr_copy[flvd_pkg::OFFSET_POS+2], hdr_copy[flvd_pkg::OFFSET_POS+3]};
          if (data_offset <= flvd_pkg::HEADER_BYTES) begin
            phase = P_PREV;
            pos = 0;
          end else begin
            phase = P_SKIP;
          end
        end
      end
      P_SKIP: begin
        pos++;
        if (pos >= data_offset) begin
          phase = P_PREV;
          pos = 0;
        end
      end
      P_PREV: begin
        if (after_vid && video_on) add_byte(flvd_pkg::KIND_VIDEO, b);
        pos++;
        if (pos >= flvd_pkg::PREV_BYTES) begin
          after_vid = 1'b0;
          phase = P_TAGHDR;
          pos = 0;
        end
      end
      P_TAGHDR: begin
        if (pos == 0) begin
          cur_type = b;
          cur_size = '0;
          cur_stamp = '0;
          if (cur_type == flvd_pkg::TYPE_VIDEO && video_on && !replay_done) begin
            for (i = 0; i < flvd_pkg::HEADER_BYTES; i++)
              add_byte(flvd_pkg::KIND_VIDEO, hdr_copy[i]);
            for (i = 0; i < flvd_pkg::ZERO_PAD_BYTES; i++)
              add_byte(flvd_pkg::KIND_VIDEO, 8'h00);
            replay_done = 1'b1;
          end
        end else if (pos <= 3) begin
          cur_size = {cur_size[15:0], b};
        end else if (pos <= 6) begin
          cur_stamp = {cur_stamp[15:0], b};
        end
        // Tags without a first payload byte describe themselves here.
        if (pos == flvd_pkg::TAGHDR_BYTES - 1 &&
            (!(cur_type == flvd_pkg::TYPE_AUDIO || cur_type == flvd_pkg::TYPE_VIDEO) ||
             cur_size == '0))
          add_desc(1'b0, 8'h00);
        if (cur_type == flvd_pkg::TYPE_VIDEO && video_on) add_byte(flvd_pkg::KIND_VIDEO, b);
        pos++;
        if (pos >= flvd_pkg::TAGHDR_BYTES) begin
          pos = 0;
          if (cur_size == '0) begin
            if (cur_type == flvd_pkg::TYPE_VIDEO) after_vid = 1'b1;
            phase = P_PREV;
          end else begin
            phase = P_BODY;
          end
        end
      end
      P_BODY: begin
        if (cur_type == flvd_pkg::TYPE_AUDIO) begin
          if (pos == 0) add_desc(1'b1, b);
          else if (audio_on) add_byte(flvd_pkg::KIND_AUDIO, b);
        end else if (cur_type == flvd_pkg::TYPE_VIDEO) begin
          if (pos == 0) add_desc(1'b1, b);
          if (video_on) add_byte(flvd_pkg::KIND_VIDEO, b);
        end
        pos++;
        if (pos >= cur_size) begin
          if (cur_type == flvd_pkg::TYPE_VIDEO) after_vid = 1'b1;
          phase = P_PREV;
          pos = 0;
        end
      end
      default: begin
        phase = P_HEADER;
        pos = 0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Input acceptance feeds the predictor; result beats are checked in order.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      fresh.delete();
      demux_byte(in_file_byte);
      case (cur_row.form)
        FORM_MODEL: foreach (fresh[i]) results_due.push_back(fresh[i]);
        FORM_TYPED: results_due.push_back(cur_row.want);
        default: ;
      endcase
      bytes_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat: kind %0h byte %0h", $time, out_kind, out_byte);
        failures++;
      end else begin
        head = results_due.pop_front();
        check_field("kind", 24'(head.kind), 24'(out_kind));
        check_field("out_byte", 24'(head.out_byte), 24'(out_byte));
        check_field("tag_type", 24'(head.tag_type), 24'(out_tag_type));
        check_field("tag_size", head.tag_size, out_tag_size);
        check_field("time_stamp", head.time_stamp, out_time_stamp);
        check_field("sound_format", 24'(head.sound_format), 24'(out_sound_format));
        check_field("sound_rate", 24'(head.sound_rate), 24'(out_sound_rate));
        check_field("sound_size", 24'(head.sound_size), 24'(out_sound_size));
        check_field("sound_channels", 24'(head.sound_channels), 24'(out_sound_channels));
        check_field("frame_kind", 24'(head.frame_kind), 24'(out_frame_kind));
        check_field("codec_id", 24'(head.codec_id), 24'(out_codec_id));
        case (head.kind)
          flvd_pkg::KIND_AUDIO: n_audio++;
          flvd_pkg::KIND_VIDEO: n_video++;
          default: n_desc++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results outstanding", $time, results_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_wanted) begin
      hold_left = HOLD_CYCLES;
      hold_wanted = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (ready_mode)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        default: out_ready = (tick % 4 != 0);
      endcase
      tick++;
    end
  end

  // Sender: bursts of beats with random gaps, holding each beat until taken.
  task automatic send_beats();
    int burst;
    int gap;
    burst = 0;
    while (beat_queue.size() > 0) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      cur_row = beat_queue.pop_front();
      in_file_byte = cur_row.value;
      in_valid = 1'b1;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
      burst--;
    end
    in_valid = 1'b0;
  endtask

  task automatic push_random(input logic [7:0] b);
    stim_row_t r;
    r.value = b;
    r.form = FORM_MODEL;
    r.want = '0;
    beat_queue.push_back(r);
  endtask

  // Appends one tag: previous-tag-size, tag header and payload.
  task automatic add_random_tag();
    logic [7:0]  ttype;
    logic [23:0] size;
    int pick;
    int i;
    pick = $urandom_range(0, 99);
    if (pick < 40) ttype = flvd_pkg::TYPE_AUDIO;
    else if (pick < 78) ttype = flvd_pkg::TYPE_VIDEO;
    else if (pick < 88) ttype = TYPE_SCRIPT;
    else ttype = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 15) size = '0;
    else if (pick < 92) size = 24'($urandom_range(1, 6));
    else size = 24'($urandom_range(7, 40));
    for (i = 0; i < flvd_pkg::PREV_BYTES; i++) push_random(8'($urandom_range(0, 255)));
    push_random(ttype);
    push_random(size[23:16]);
    push_random(size[15:8]);
    push_random(size[7:0]);
    for (i = 0; i < 7; i++) push_random(8'($urandom_range(0, 255)));
    for (i = 0; i < size; i++) push_random(8'($urandom_range(0, 255)));
  endtask

  task automatic write_enable(input logic idx, input logic val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == flvd_pkg::CFG_AUDIO_ENABLE) audio_on = val;
    else video_on = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [1:0] plan [4];
    logic [1:0] setting;
    int ph;
    plan = '{2'b01, 2'b10, 2'b00, 2'b11};
    // File header with a data offset of nine, so nothing is skipped, then an
    // empty video tag: the type byte triggers the replay of the stored header.
    intro = '{
      '{8'h46, FORM_QUIET, '0}, '{8'h4C, FORM_QUIET, '0}, '{8'h56, FORM_QUIET, '0},
      '{8'hFF, FORM_QUIET, '0}, '{8'h05, FORM_QUIET, '0},
      '{8'h00, FORM_QUIET, '0}, '{8'h00, FORM_QUIET, '0}, '{8'h00, FORM_QUIET, '0},
      '{8'h09, FORM_QUIET, '0},
      '{8'h00, FORM_QUIET, '0}, '{8'h00, FORM_QUIET, '0}, '{8'h00, FORM_QUIET, '0},
      '{8'h00, FORM_QUIET, '0},
      '{flvd_pkg::TYPE_VIDEO, FORM_MODEL, '0},
      '{8'h00, FORM_TYPED, echo(8'h00)}, '{8'h00, FORM_TYPED, echo(8'h00)},
      '{8'h00, FORM_TYPED, echo(8'h00)},
      '{8'hFF, FORM_TYPED, echo(8'hFF)}, '{8'hFF, FORM_TYPED, echo(8'hFF)},
      '{8'hFF, FORM_TYPED, echo(8'hFF)}, '{8'hFF, FORM_TYPED, echo(8'hFF)},
      '{8'h00, FORM_TYPED, echo(8'h00)}, '{8'h00, FORM_TYPED, echo(8'h00)},
      '{8'h00, FORM_MODEL, '0}
    };
    cur_row = intro[0];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (intro[i]) beat_queue.push_back(intro[i]);
    send_beats();

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      setting = (ph < 4) ? plan[ph] : 2'($urandom_range(0, 3));
      write_enable(flvd_pkg::CFG_AUDIO_ENABLE, setting[1]);
      write_enable(flvd_pkg::CFG_VIDEO_ENABLE, setting[0]);
      while (beat_queue.size() < PHASE_BYTES) add_random_tag();
      // With both routes on, a long receiver hold-off backs up the input.
      if (ph == 3) hold_wanted = 1'b1;
      send_beats();
    end

    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Parsed %0d file bytes across %0d enable settings, with a long output stall.",
             bytes_taken, PHASES + 1);
    $display("Checked %0d audio bytes, %0d video bytes and %0d tag descriptors.",
             n_audio, n_video, n_desc);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/flvd_pkg.sv
src/flvd_front.sv
src/flvd_cmd_fifo.sv
src/flvd_back.sv
src/flv_tag_demultiplexer_top.sv
test/tb_flv_tag_demultiplexer_top.sv
